// ===== src/bbu_pkg.sv =====
`timescale 1ns / 1ps

package bbu_pkg;

  localparam int FRAC_BITS = 24;
  localparam int PROB_W    = FRAC_BITS + 1;
  localparam int DENS_W    = FRAC_BITS + 8;
  localparam int FLOOR_W   = 24;
  localparam int PROD_W    = DENS_W + PROB_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int HYP_W     = 2 * PROB_W;

  localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(17);
  localparam logic [PROB_W-1:0]  ONE_Q       = {1'b1, {FRAC_BITS{1'b0}}};

  // Input stream packing, lowest bits first
  localparam int OFF_BG_HERE = 0;
  localparam int OFF_FG_HERE = OFF_BG_HERE + PROB_W;
  localparam int OFF_BG_NB   = OFF_FG_HERE + PROB_W;
  localparam int OFF_FG_NB   = OFF_BG_NB + PROB_W;
  localparam int OFF_D_FF    = OFF_FG_NB + PROB_W;
  localparam int OFF_D_FB    = OFF_D_FF + DENS_W;
  localparam int OFF_D_BF    = OFF_D_FB + DENS_W;
  localparam int OFF_D_BB    = OFF_D_BF + DENS_W;
  localparam int IN_BITS     = OFF_D_BB + DENS_W;
  localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((PROB_W + 7) / 8) * 8;

  // Winning hypothesis
  localparam logic [1:0] SEL_BB = 2'd0;
  localparam logic [1:0] SEL_BF = 2'd1;
  localparam logic [1:0] SEL_FB = 2'd2;
  localparam logic [1:0] SEL_FF = 2'd3;

  typedef struct packed {
    logic [PROB_W-1:0] bg_prob_here;
    logic [PROB_W-1:0] fg_prob_here;
    logic [PROB_W-1:0] bg_prob_neighbor;
    logic [PROB_W-1:0] fg_prob_neighbor;
    logic [DENS_W-1:0] density_ff;
    logic [DENS_W-1:0] density_fb;
    logic [DENS_W-1:0] density_bf;
    logic [DENS_W-1:0] density_bb;
  } in_item_t;

  typedef struct packed {
    logic [SUM_W-1:0]     rem;
    logic [SUM_W-1:0]     den;
    logic [FRAC_BITS-1:0] quo;
    logic                 compl;
    logic                 sat;
    logic                 reject;
    logic [PROB_W-1:0]    pb;
  } div_item_t;

endpackage

// ===== src/bbu_front.sv =====
`timescale 1ns / 1ps

module bbu_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bbu_pkg::in_item_t               in_item,
  input  logic [bbu_pkg::FLOOR_W-1:0]     floor_val,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bbu_pkg::div_item_t              out_item
);

  logic en1, en2, en3;
  logic v1, v2;

  // stage 1: products
  logic [bbu_pkg::PROB_W-1:0] om;
  logic [bbu_pkg::PROD_W-1:0] p_bb, p_bf, p_ff, p_fb, p_fb_om, p_ff_om;
  logic [bbu_pkg::HYP_W-1:0]  h_bb, h_bf, h_fb, h_ff;
  logic [bbu_pkg::PROB_W-1:0] pb1;

  // stage 2: denominators and hypothesis pick
  logic [bbu_pkg::SUM_W-1:0]  d1, d2;
  logic [1:0]                 sel;
  logic [1:0]                 sel_next;
  logic [bbu_pkg::PROD_W-1:0] n_bb, n_bf, n_fb, n_ff;
  logic [bbu_pkg::PROB_W-1:0] pb2;

  // stage 3: divider setup
  logic [bbu_pkg::SUM_W-1:0]  fs;
  logic [bbu_pkg::PROD_W-1:0] num;
  logic [bbu_pkg::SUM_W-1:0]  den;
  logic                       compl;
  logic                       reject_next;

  assign en3      = !out_valid || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  assign om = in_item.bg_prob_here[bbu_pkg::PROB_W-1] ? '0
            : bbu_pkg::ONE_Q - in_item.bg_prob_here;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
    if (en1) begin
      p_bb    <= bbu_pkg::PROD_W'(in_item.density_bb) * bbu_pkg::PROD_W'(in_item.bg_prob_here);
      p_bf    <= bbu_pkg::PROD_W'(in_item.density_bf) * bbu_pkg::PROD_W'(in_item.bg_prob_here);
      p_ff    <= bbu_pkg::PROD_W'(in_item.density_ff) * bbu_pkg::PROD_W'(in_item.fg_prob_here);
      p_fb    <= bbu_pkg::PROD_W'(in_item.density_fb) * bbu_pkg::PROD_W'(in_item.fg_prob_here);
      p_fb_om <= bbu_pkg::PROD_W'(in_item.density_fb) * bbu_pkg::PROD_W'(om);
      p_ff_om <= bbu_pkg::PROD_W'(in_item.density_ff) * bbu_pkg::PROD_W'(om);
      h_bb    <= bbu_pkg::HYP_W'(in_item.bg_prob_here) * bbu_pkg::HYP_W'(in_item.bg_prob_neighbor);
      h_bf    <= bbu_pkg::HYP_W'(in_item.bg_prob_here) * bbu_pkg::HYP_W'(in_item.fg_prob_neighbor);
      h_fb    <= bbu_pkg::HYP_W'(in_item.fg_prob_here) * bbu_pkg::HYP_W'(in_item.bg_prob_neighbor);
      h_ff    <= bbu_pkg::HYP_W'(in_item.fg_prob_here) * bbu_pkg::HYP_W'(in_item.fg_prob_neighbor);
      pb1     <= in_item.bg_prob_here;
    end
  end

  // first maximum in the order bb, bf, fb, ff wins
  always_comb begin
    if (h_bb >= h_bf && h_bb >= h_fb && h_bb >= h_ff) begin
      sel_next = bbu_pkg::SEL_BB;
    end else if (h_bf >= h_fb && h_bf >= h_ff) begin
      sel_next = bbu_pkg::SEL_BF;
    end else if (h_fb >= h_ff) begin
      sel_next = bbu_pkg::SEL_FB;
    end else begin
      sel_next = bbu_pkg::SEL_FF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      d1   <= bbu_pkg::SUM_W'(p_bf) + bbu_pkg::SUM_W'(p_ff);
      d2   <= bbu_pkg::SUM_W'(p_bb) + bbu_pkg::SUM_W'(p_fb);
      sel  <= sel_next;
      n_bb <= p_bb;
      n_bf <= p_bf;
      n_fb <= p_fb_om;
      n_ff <= p_ff_om;
      pb2  <= pb1;
    end
  end

  assign fs = bbu_pkg::SUM_W'(floor_val) << bbu_pkg::FRAC_BITS;
  assign reject_next = (d1 == '0) || (d2 == '0) || (d1 < fs) || (d2 < fs);

  always_comb begin
    case (sel)
      bbu_pkg::SEL_BB: begin num = n_bb; den = d2; compl = 1'b0; end
      bbu_pkg::SEL_BF: begin num = n_bf; den = d1; compl = 1'b0; end
      bbu_pkg::SEL_FB: begin num = n_fb; den = d2; compl = 1'b1; end
      default:         begin num = n_ff; den = d1; compl = 1'b1; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en3) begin
      out_valid <= v2;
    end
    if (en3) begin
      out_item.rem    <= bbu_pkg::SUM_W'(num);
      out_item.den    <= den;
      out_item.quo    <= '0;
      out_item.compl  <= compl;
      out_item.sat    <= bbu_pkg::SUM_W'(num) >= den;
      out_item.reject <= reject_next;
      out_item.pb     <= pb2;
    end
  end

  a_zero_den_rejects: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.den == '0 |-> out_item.reject)
    else $error("zero denominator reached the divider unrejected");

  a_setup_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.reject && !out_item.sat |-> out_item.rem < out_item.den)
    else $error("divider setup with numerator not below denominator");

endmodule

// ===== src/bbu_div.sv =====
`timescale 1ns / 1ps

module bbu_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bbu_pkg::div_item_t          in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bbu_pkg::PROB_W-1:0]  out_prob,
  output logic                        out_updated
);

  localparam int N = bbu_pkg::FRAC_BITS;

  logic [N:0]         pv;
  logic [N:0]         en;
  bbu_pkg::div_item_t pd [N+1];

  logic [bbu_pkg::PROB_W-1:0] ratio;
  logic [bbu_pkg::PROB_W-1:0] value;

  always_comb begin
    pv[0] = in_valid;
    pd[0] = in_item;
  end

  assign in_ready = en[0];
  assign en[N]    = !out_valid || out_ready;

  // one restoring quotient bit per stage
  for (genvar k = 0; k < N; k++) begin : g_step
    logic [bbu_pkg::SUM_W:0]   r2;
    logic                      ge;
    logic [bbu_pkg::SUM_W-1:0] rem_next;
    bbu_pkg::div_item_t        stage_next;

    assign en[k]    = !pv[k+1] || en[k+1];
    assign r2       = {pd[k].rem, 1'b0};
    assign ge       = r2 >= {1'b0, pd[k].den};
    assign rem_next = ge ? bbu_pkg::SUM_W'(r2 - {1'b0, pd[k].den})
                         : bbu_pkg::SUM_W'(r2);

    always_comb begin
      stage_next     = pd[k];
      stage_next.rem = rem_next;
      stage_next.quo = {pd[k].quo[N-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pv[k+1] <= 1'b0;
      end else if (en[k]) begin
        pv[k+1] <= pv[k];
      end
      if (en[k]) begin
        pd[k+1] <= stage_next;
      end
    end
  end

  assign ratio = pd[N].sat ? bbu_pkg::ONE_Q : {1'b0, pd[N].quo};
  assign value = pd[N].compl ? bbu_pkg::ONE_Q - ratio : ratio;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en[N]) begin
      out_valid <= pv[N];
    end
    if (en[N]) begin
      out_prob    <= pd[N].reject ? pd[N].pb : value;
      out_updated <= !pd[N].reject;
    end
  end

  a_final_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    pv[N] && !pd[N].reject && !pd[N].sat |-> pd[N].rem < pd[N].den)
    else $error("divider remainder escaped its bound");

  a_updated_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_updated |-> out_prob <= bbu_pkg::ONE_Q)
    else $error("updated probability above one");

endmodule

// ===== src/pairwise_bayes_background_update.sv =====
// Pairwise background update: one pixel's background probability is revised
// from a neighbor pair and four pair densities (all unsigned fixed point,
// 24 fraction bits).
// Channels:
//   s_axis  - one item per pixel pair: the four probabilities and four
//             densities packed in tdata.
//   m_axis  - one result per item, in order: new background probability in
//             tdata, the updated flag in tuser (0 when a denominator was zero or
//             fell below the floor and the input probability is passed through).
//   cfg     - write of the denominator floor (Q0.24); write it only while
//             no item is in flight.
// Pipeline: three front stages for the products, denominators and divider
// setup, one restoring divider stage per quotient bit, and the output
// register. Throughput is one item per cycle while m_axis does not stall.
// Reset empties the pipeline and sets the floor to 17. When m_axis stalls,
// the stages fill up behind it and s_axis tready drops only once no stage
// is free; nothing is lost or repeated.
`timescale 1ns / 1ps

module pairwise_bayes_background_update (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // bg_prob_here, fg_prob_here, bg_prob_neighbor, fg_prob_neighbor,
  // density_ff, density_fb, density_bf, density_bb, zero pad
  input  logic [bbu_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // new_bg_prob, zero pad
  output logic [bbu_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // updated
  output logic [0:0]                         m_axis_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bbu_pkg::FLOOR_W-1:0]        cfg_data
);

  logic [bbu_pkg::FLOOR_W-1:0] floor_val;
  bbu_pkg::in_item_t           in_item;
  bbu_pkg::div_item_t          div_item;
  logic                        div_valid;
  logic                        div_ready;
  logic [bbu_pkg::PROB_W-1:0]  new_bg_prob;
  logic                        updated;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_val <= bbu_pkg::FLOOR_RESET;
    end else if (cfg_valid) begin
      floor_val <= cfg_data;
    end
  end

  assign in_item.bg_prob_here     = s_axis_tdata[bbu_pkg::OFF_BG_HERE +: bbu_pkg::PROB_W];
  assign in_item.fg_prob_here     = s_axis_tdata[bbu_pkg::OFF_FG_HERE +: bbu_pkg::PROB_W];
  assign in_item.bg_prob_neighbor = s_axis_tdata[bbu_pkg::OFF_BG_NB +: bbu_pkg::PROB_W];
  assign in_item.fg_prob_neighbor = s_axis_tdata[bbu_pkg::OFF_FG_NB +: bbu_pkg::PROB_W];
  assign in_item.density_ff       = s_axis_tdata[bbu_pkg::OFF_D_FF +: bbu_pkg::DENS_W];
  assign in_item.density_fb       = s_axis_tdata[bbu_pkg::OFF_D_FB +: bbu_pkg::DENS_W];
  assign in_item.density_bf       = s_axis_tdata[bbu_pkg::OFF_D_BF +: bbu_pkg::DENS_W];
  assign in_item.density_bb       = s_axis_tdata[bbu_pkg::OFF_D_BB +: bbu_pkg::DENS_W];

  bbu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (in_item),
    .floor_val (floor_val),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_item  (div_item)
  );

  bbu_div u_div (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (div_valid),
    .in_ready    (div_ready),
    .in_item     (div_item),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_prob    (new_bg_prob),
    .out_updated (updated)
  );

  assign m_axis_tdata = bbu_pkg::OUT_DATA_W'(new_bg_prob);
  assign m_axis_tuser = updated;

endmodule
